// ----- rtl/core/kte_pkg.sv -----
// Package for the tilt estimator: payload structs, controller/datapath links,
// arithmetic constants and saturation helper. No dependencies.
`timescale 1ns / 1ps

package kte_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_W        = 32;
   localparam int NOISE_W        = 31;
   localparam int DT_W           = 16;
   localparam int COV_W          = 32;
   localparam int MUL_A_W        = 50;
   localparam int MUL_K_W        = 33;
   localparam int MUL_SPLIT      = 25;
   localparam int ACC_W          = MUL_A_W + MUL_K_W;
   localparam int WIDE_W         = 64;
   localparam int SHIFT_DT       = 16;
   localparam int SHIFT_Q30      = 30;
   localparam int CSR_IDX_W      = 2;
   localparam int OP_W           = 4;

   localparam logic [NOISE_W-1:0] Q_ANGLE_RST = NOISE_W'(1073742);
   localparam logic [NOISE_W-1:0] Q_GYRO_RST  = NOISE_W'(1073742);
   localparam logic [NOISE_W-1:0] R_ANGLE_RST = NOISE_W'(536870912);
   localparam logic [DT_W-1:0]    DT_RST      = DT_W'(328);
   localparam logic signed [COV_W-1:0] COV_ONE = COV_W'(1 << 30);

   localparam logic [CSR_IDX_W-1:0] CSR_Q_ANGLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_GYRO    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_R_ANGLE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME = 2'd3;

   // multiply-accumulate operations, issued in this order
   localparam logic [OP_W-1:0] OP_ANGLE_PRED = 4'd0;
   localparam logic [OP_W-1:0] OP_P00_PRED   = 4'd1;
   localparam logic [OP_W-1:0] OP_PCROSS_PRED= 4'd2;
   localparam logic [OP_W-1:0] OP_P11_PRED   = 4'd3;
   localparam logic [OP_W-1:0] OP_P00_UPD    = 4'd4;
   localparam logic [OP_W-1:0] OP_P01_UPD    = 4'd5;
   localparam logic [OP_W-1:0] OP_P10_UPD    = 4'd6;
   localparam logic [OP_W-1:0] OP_P11_UPD    = 4'd7;
   localparam logic [OP_W-1:0] OP_ANGLE_UPD  = 4'd8;
   localparam logic [OP_W-1:0] OP_BIAS_UPD   = 4'd9;

   typedef struct packed {
      logic signed [FIELD_W-1:0] accel_angle;
      logic signed [FIELD_W-1:0] gyro_rate;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] angle_estimate;
      logic signed [FIELD_W-1:0] rate_estimate;
      logic signed [FIELD_W-1:0] bias_estimate;
   } rsp_type;

   typedef struct packed {
      logic            capture;
      logic            rate_en;
      logic            mul_lo;
      logic            mul_hi;
      logic            mul_wb;
      logic            err_en;
      logic            div_start;
      logic            fin;
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic e_pos;
      logic div_done;
   } sts_type;

   function automatic logic signed [WIDE_W-1:0] sat_wide(
      input logic signed [WIDE_W-1:0] x, input int unsigned bits);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = (WIDE_W'(1) <<< (bits - 1)) - WIDE_W'(1);
      lo = -hi - WIDE_W'(1);
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

endpackage

// ----- rtl/core/kte_div.sv -----
// Two-lane restoring divider for the Kalman gains: (num << 30) / den, one
// quotient bit per cycle, saturated to Q2.30. Depends on kte_pkg.
`timescale 1ns / 1ps

module kte_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [kte_pkg::COV_W-1:0]  num0,
   input  logic signed [kte_pkg::COV_W-1:0]  num1,
   input  logic [kte_pkg::COV_W-1:0]         den,
   output logic                              done,
   output logic signed [kte_pkg::COV_W-1:0]  quo0,
   output logic signed [kte_pkg::COV_W-1:0]  quo1
);
   import kte_pkg::*;

   localparam int CNT_W = $clog2(COV_W);

   logic                   busy_ff, busy_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [COV_W-1:0]       den_ff, den_in;
   logic [1:0][COV_W-1:0]  rem_ff, rem_in, low_ff, low_in, q_ff, q_in;
   logic [1:0]             neg_ff, neg_in, ovf_ff, ovf_in;
   logic [1:0][COV_W-1:0]  num_w;
   logic [1:0][COV_W-1:0]  res_w;

   assign num_w[0] = num0;
   assign num_w[1] = num1;
   assign done     = busy_ff && (cnt_ff == CNT_W'(COV_W - 1));

   always_comb begin
      logic [COV_W-1:0] mag;
      logic [COV_W:0]   trial;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      ovf_in  = ovf_ff;
      mag     = '0;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = den;
         for (int l = 0; l < 2; l++) begin
            mag       = num_w[l][COV_W-1] ? (~num_w[l] + COV_W'(1)) : num_w[l];
            neg_in[l] = num_w[l][COV_W-1];
            ovf_in[l] = {2'b00, mag[COV_W-1:2]} >= den;
            rem_in[l] = {2'b00, mag[COV_W-1:2]};
            low_in[l] = {mag[1:0], {(COV_W-2){1'b0}}};
            q_in[l]   = '0;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (done) busy_in = 1'b0;
         for (int l = 0; l < 2; l++) begin
            trial     = {rem_ff[l], low_ff[l][COV_W-1]};
            low_in[l] = {low_ff[l][COV_W-2:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               trial     = trial - {1'b0, den_ff};
               q_in[l]   = {q_ff[l][COV_W-2:0], 1'b1};
            end else begin
               q_in[l]   = {q_ff[l][COV_W-2:0], 1'b0};
            end
            rem_in[l] = trial[COV_W-1:0];
         end
      end
   end

   // saturate the magnitude and apply the sign
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (!neg_ff[l]) begin
            res_w[l] = (ovf_ff[l] || q_ff[l][COV_W-1]) ? {1'b0, {(COV_W-1){1'b1}}} : q_ff[l];
         end else begin
            res_w[l] = (ovf_ff[l] || q_ff[l][COV_W-1]) ? {1'b1, {(COV_W-1){1'b0}}}
                                                      : (~q_ff[l] + COV_W'(1));
         end
      end
   end

   assign quo0 = res_w[0];
   assign quo1 = res_w[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy_ff) else $error("divider still busy after last step");

endmodule

// ----- rtl/core/kte_datapath.sv -----
// Datapath of the tilt estimator: filter state, configuration registers,
// shared two-pass multiplier, gain divider and result register. Uses kte_pkg, kte_div.
`timescale 1ns / 1ps

module kte_datapath #(
   parameter int DATA_WIDTH = kte_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [kte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kte_pkg::NOISE_W-1:0]       csr_wdata,
   input  kte_pkg::req_type                  req_data,
   input  kte_pkg::cmd_type                  cmd,
   output kte_pkg::sts_type                  sts,
   output kte_pkg::rsp_type                  rsp_data
);
   import kte_pkg::*;

   logic [NOISE_W-1:0] q_angle_ff, q_gyro_ff, r_angle_ff;
   logic [DT_W-1:0]    dt_ff;

   logic signed [DATA_WIDTH-1:0] angle_ff, bias_ff, rate_ff;
   logic signed [COV_W-1:0]      p00_ff, p01_ff, p10_ff, p11_ff, t0_ff, t1_ff;
   logic signed [FIELD_W-1:0]    accel_ff, gyro_ff;
   logic signed [MUL_A_W-1:0]    err_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   rsp_type                      rsp_ff;

   logic signed [WIDE_W-1:0]     rate_w, pdot0_w, res_w, shifted_lo;
   logic signed [ACC_W-1:0]      shifted_w, prod_lo, prod_hi, round_w;
   logic signed [MUL_A_W-1:0]    a_w;
   logic signed [MUL_K_W-1:0]    k_w, dt_k;
   logic signed [MUL_A_W-MUL_SPLIT-1:0] a_hi;
   logic signed [MUL_SPLIT:0]    a_lo;
   logic                         sh_dt;
   logic signed [COV_W:0]        e_w;
   logic signed [COV_W-1:0]      k0_w, k1_w;

   assign rate_w  = sat_wide(WIDE_W'(gyro_ff) - WIDE_W'(bias_ff), DATA_WIDTH);
   assign pdot0_w = $signed(WIDE_W'(q_angle_ff)) - WIDE_W'(p01_ff) - WIDE_W'(p10_ff);
   assign dt_k    = $signed(MUL_K_W'(dt_ff));
   assign e_w     = $signed({2'b00, r_angle_ff}) + (COV_W+1)'(p00_ff);
   assign sts.e_pos = !e_w[COV_W] && (e_w != '0);

   kte_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num0  (p00_ff),
      .num1  (p10_ff),
      .den   (e_w[COV_W-1:0]),
      .done  (sts.div_done),
      .quo0  (k0_w),
      .quo1  (k1_w)
   );

   // operand select for the shared multiplier
   always_comb begin
      sh_dt = 1'b0;
      a_w   = '0;
      k_w   = '0;
      case (cmd.op)
         OP_ANGLE_PRED:  begin a_w = MUL_A_W'(rate_ff);  k_w = dt_k; sh_dt = 1'b1; end
         OP_P00_PRED:    begin a_w = MUL_A_W'(pdot0_w);  k_w = dt_k; sh_dt = 1'b1; end
         OP_PCROSS_PRED: begin
            a_w = -MUL_A_W'(p11_ff); k_w = dt_k; sh_dt = 1'b1;
         end
         OP_P11_PRED:    begin
            a_w = $signed(MUL_A_W'(q_gyro_ff)); k_w = dt_k; sh_dt = 1'b1;
         end
         OP_P00_UPD:     begin a_w = MUL_A_W'(t0_ff); k_w = MUL_K_W'(k0_w); end
         OP_P01_UPD:     begin a_w = MUL_A_W'(t1_ff); k_w = MUL_K_W'(k0_w); end
         OP_P10_UPD:     begin a_w = MUL_A_W'(t0_ff); k_w = MUL_K_W'(k1_w); end
         OP_P11_UPD:     begin a_w = MUL_A_W'(t1_ff); k_w = MUL_K_W'(k1_w); end
         OP_ANGLE_UPD:   begin a_w = err_ff;          k_w = MUL_K_W'(k0_w); end
         OP_BIAS_UPD:    begin a_w = err_ff;          k_w = MUL_K_W'(k1_w); end
         default:        begin a_w = '0;              k_w = '0; end
      endcase
   end

   assign a_lo      = $signed({1'b0, a_w[MUL_SPLIT-1:0]});
   assign a_hi      = a_w[MUL_A_W-1:MUL_SPLIT];
   assign prod_lo   = a_lo * k_w;
   assign prod_hi   = a_hi * k_w;
   assign round_w   = sh_dt ? (ACC_W'(1) <<< (SHIFT_DT - 1)) : (ACC_W'(1) <<< (SHIFT_Q30 - 1));
   assign shifted_w = sh_dt ? (acc_ff >>> SHIFT_DT) : (acc_ff >>> SHIFT_Q30);
   assign shifted_lo = shifted_w[WIDE_W-1:0];
   assign res_w     = shifted_lo;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_angle_ff <= Q_ANGLE_RST;
         q_gyro_ff  <= Q_GYRO_RST;
         r_angle_ff <= R_ANGLE_RST;
         dt_ff      <= DT_RST;
         angle_ff   <= '0;
         bias_ff    <= '0;
         p00_ff     <= COV_ONE;
         p01_ff     <= '0;
         p10_ff     <= '0;
         p11_ff     <= COV_ONE;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_Q_ANGLE:   q_angle_ff <= csr_wdata;
               CSR_Q_GYRO:    q_gyro_ff  <= csr_wdata;
               CSR_R_ANGLE:   r_angle_ff <= csr_wdata;
               CSR_STEP_TIME: dt_ff      <= csr_wdata[DT_W-1:0];
               default:       dt_ff      <= dt_ff;
            endcase
         end
         if (cmd.mul_wb) begin
            case (cmd.op)
               OP_ANGLE_PRED: angle_ff <= DATA_WIDTH'(sat_wide(WIDE_W'(angle_ff) + res_w,
                                                               DATA_WIDTH));
               OP_P00_PRED:   p00_ff <= COV_W'(sat_wide(WIDE_W'(p00_ff) + res_w, COV_W));
               OP_PCROSS_PRED: begin
                  p01_ff <= COV_W'(sat_wide(WIDE_W'(p01_ff) + res_w, COV_W));
                  p10_ff <= COV_W'(sat_wide(WIDE_W'(p10_ff) + res_w, COV_W));
               end
               OP_P11_PRED:   p11_ff <= COV_W'(sat_wide(WIDE_W'(p11_ff) + res_w, COV_W));
               OP_P00_UPD:    p00_ff <= COV_W'(sat_wide(WIDE_W'(p00_ff) - res_w, COV_W));
               OP_P01_UPD:    p01_ff <= COV_W'(sat_wide(WIDE_W'(p01_ff) - res_w, COV_W));
               OP_P10_UPD:    p10_ff <= COV_W'(sat_wide(WIDE_W'(p10_ff) - res_w, COV_W));
               OP_P11_UPD:    p11_ff <= COV_W'(sat_wide(WIDE_W'(p11_ff) - res_w, COV_W));
               OP_ANGLE_UPD:  angle_ff <= DATA_WIDTH'(sat_wide(WIDE_W'(angle_ff) + res_w,
                                                               DATA_WIDTH));
               OP_BIAS_UPD:   bias_ff <= DATA_WIDTH'(sat_wide(WIDE_W'(bias_ff) + res_w,
                                                              DATA_WIDTH));
               default:       bias_ff <= bias_ff;
            endcase
         end
      end
   end

   // payload, working and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         accel_ff <= req_data.accel_angle;
         gyro_ff  <= req_data.gyro_rate;
      end
      if (cmd.rate_en) rate_ff <= DATA_WIDTH'(rate_w);
      if (cmd.mul_lo) acc_ff <= prod_lo + round_w;
      if (cmd.mul_hi) acc_ff <= acc_ff + (prod_hi <<< MUL_SPLIT);
      if (cmd.err_en) begin
         err_ff <= MUL_A_W'(WIDE_W'(accel_ff) - WIDE_W'(angle_ff));
         t0_ff  <= p00_ff;
         t1_ff  <= p01_ff;
      end
      if (cmd.fin) begin
         rsp_ff.angle_estimate <= FIELD_W'(WIDE_W'(angle_ff));
         rsp_ff.rate_estimate  <= FIELD_W'(rate_w);
         rsp_ff.bias_estimate  <= FIELD_W'(WIDE_W'(bias_ff));
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/core/kte_ctrl.sv -----
// Sequencer of the tilt estimator: walks predict, then gain division and update when r_angle + P00 > 0,
// drives the datapath commands and both handshakes. Uses kte_pkg.
`timescale 1ns / 1ps

module kte_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  kte_pkg::sts_type  sts,
   output kte_pkg::cmd_type  cmd
);
   import kte_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_IDLE = 3'd0;
   localparam logic [ST_W-1:0] S_RATE = 3'd1;
   localparam logic [ST_W-1:0] S_MLO  = 3'd2;
   localparam logic [ST_W-1:0] S_MHI  = 3'd3;
   localparam logic [ST_W-1:0] S_MWB  = 3'd4;
   localparam logic [ST_W-1:0] S_ERR  = 3'd5;
   localparam logic [ST_W-1:0] S_DIV  = 3'd6;
   localparam logic [ST_W-1:0] S_FIN  = 3'd7;

   logic [ST_W-1:0] state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.op       = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_RATE;
            end
         end
         S_RATE: begin
            cmd.rate_en = 1'b1;
            op_in       = OP_ANGLE_PRED;
            state_in    = S_MLO;
         end
         S_MLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MHI;
         end
         S_MHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_MWB;
         end
         S_MWB: begin
            cmd.mul_wb = 1'b1;
            if (op_ff == OP_P11_PRED) begin
               state_in = S_ERR;
            end else if (op_ff == OP_BIAS_UPD) begin
               state_in = S_FIN;
            end else begin
               op_in    = op_ff + OP_W'(1);
               state_in = S_MLO;
            end
         end
         S_ERR: begin
            cmd.err_en = 1'b1;
            if (sts.e_pos) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               // no valid gain: keep the predicted state
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               op_in    = OP_P00_UPD;
               state_in = S_MLO;
            end
         end
         S_FIN: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.fin      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_ANGLE_PRED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_div_from_err: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (state_ff == S_ERR) && sts.e_pos)
      else $error("divider started outside the gain step");
   a_err_after_predict: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERR) |-> (op_ff == OP_P11_PRED))
      else $error("update entered before predict finished");
   a_wb_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MWB) |=> (state_ff == S_MLO) || (state_ff == S_ERR) || (state_ff == S_FIN))
      else $error("bad state after write-back");
   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> rsp_valid_ff)
      else $error("result not presented after load");

endmodule

// ----- rtl/core/kalman_tilt_estimator_top.sv -----
// Two-state (angle, gyro bias) Kalman tilt estimator, fixed point.
// One item in flight: a new item is stalled until the result of the last one is loaded;
// when r_angle + P00 <= 0 the gain division and update are skipped.
// The work runs on the 32-step gain divider and up to ten two-pass multiplies on the shared multiplier.
// Reset (synchronous): registers to defaults, angle and bias zero, P = identity.
// Depends on kte_pkg, kte_ctrl, kte_datapath.
`timescale 1ns / 1ps

module kalman_tilt_estimator_top #(
   parameter int DATA_WIDTH = kte_pkg::DATA_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  kte_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output kte_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_en,
   input  logic [kte_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kte_pkg::NOISE_W-1:0]    csr_wdata
);
   import kte_pkg::*;

   cmd_type cmd;
   sts_type sts;

   kte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kte_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_data     (rsp_data)
   );

endmodule
